// ===== hw/rtl/svp_pkg.sv =====
// Shared types, widths and register codes for the shadow vertex projector.
`timescale 1ns / 1ps

package svp_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DX_WIDTH    = COORD_WIDTH + 2;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH + 1;
    localparam int ROOT_WIDTH  = COORD_WIDTH + 2;
    localparam int NUM_WIDTH   = 2 * COORD_WIDTH + 1;
    localparam int QUO_WIDTH   = COORD_WIDTH + 2;
    localparam int DEN_WIDTH   = COORD_WIDTH + 2;
    localparam int WSUM_WIDTH  = 10;
    localparam int HPROD_WIDTH = COORD_WIDTH - 1 + WSUM_WIDTH;
    localparam int FILL_WIDTH  = 11;
    localparam int CHAN_STEP   = 255;

    localparam logic [FILL_WIDTH-1:0] FILL_MAX = FILL_WIDTH'(4 * CHAN_STEP);
    localparam logic [7:0]            CHAN_MAX = 8'(CHAN_STEP);

    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIGHT_X       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIGHT_Y       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIGHT_Z       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIGHT_RADIUS  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBJECT_X      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBJECT_Y      = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBJECT_Z      = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CASTER_HEIGHT = 3'd7;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic [7:0]                    weight_r;
        logic [7:0]                    weight_g;
        logic [7:0]                    weight_b;
        logic [7:0]                    weight_a;
    } item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] shadow_x;
        logic signed [COORD_WIDTH-1:0] shadow_y;
        logic [7:0]                    fill_r;
        logic [7:0]                    fill_g;
        logic [7:0]                    fill_b;
        logic [7:0]                    fill_a;
        logic                          hits_ground;
    } result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] light_x;
        logic signed [COORD_WIDTH-1:0] light_y;
        logic signed [COORD_WIDTH-1:0] light_z;
        logic [COORD_WIDTH-2:0]        light_radius;
        logic signed [COORD_WIDTH-1:0] object_x;
        logic signed [COORD_WIDTH-1:0] object_y;
        logic signed [COORD_WIDTH-1:0] object_z;
        logic [COORD_WIDTH-2:0]        caster_height;
    } cfg_t;

    typedef struct packed {
        logic signed [DX_WIDTH-1:0] dx;
        logic signed [DX_WIDTH-1:0] dy;
        logic signed [DX_WIDTH-1:0] dz;
        logic [SQ_WIDTH-1:0]        sum_sq;
        logic [7:0]                 weight_r;
    } front_t;

    typedef struct packed {
        logic signed [DX_WIDTH-1:0] dx;
        logic signed [DX_WIDTH-1:0] dy;
        logic signed [DX_WIDTH-1:0] dz;
        logic [7:0]                 weight_r;
    } side_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic hits_ground;
        logic dist_zero;
    } post_t;

endpackage

// ===== hw/rtl/shadow_vertex_projector.sv =====
// Top level of the shadow vertex projector: config registers, branch select and output.
//
//   channel   signals                      transfer
//   -------   --------------------------   ------------------------------------
//   input     start, busy, item            start high and busy low at the edge
//   result    done, result                 done high for one cycle, no stall
//   config    wr_en, wr_index, wr_data     wr_en high at the edge
//
// One vertex enters per cycle; busy stays low. A result shows once its start transfer
// has passed 6 front stages, 26 square root stages, 1 select stage, 27 divider stages
// and the output register.
// Reset clears the config registers and all valid bits; data registers are not reset.
// The result side cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps

module shadow_vertex_projector
    import svp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  item_t                      item,
    output logic                       done,
    output result_t                    result,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [COORD_WIDTH-1:0]     wr_data
);

    localparam int DIV_LAT   = QUO_WIDTH + 1;
    localparam int SUM_WIDTH = QUO_WIDTH + 2;

    cfg_t cfg_reg;

    logic   front_valid;
    front_t front_data;
    logic [ROOT_WIDTH-1:0] root;

    side_t                 side_reg   [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] side_v_reg;
    side_t                 side_cur;

    logic [NUM_WIDTH-1:0] num_x_reg, num_x_next, num_y_reg, num_y_next;
    logic [NUM_WIDTH-1:0] num_f_reg, num_f_next;
    logic [DEN_WIDTH-1:0] den_reg, den_next;
    post_t                sel_post_reg, sel_post_next;
    logic                 sel_v_reg;

    logic [QUO_WIDTH-1:0] quo_x, quo_y, quo_f;

    post_t              post_reg   [DIV_LAT];
    logic [DIV_LAT-1:0] post_v_reg;
    post_t              post_cur;

    logic                  above, dist_zero, dx_neg, dy_neg, lz_pos;
    logic [MAG_WIDTH-1:0]  mag_dx, mag_dy;
    logic [DEN_WIDTH-1:0]  mag_dz;
    logic [COORD_WIDTH-1:0] lz_mag, scale;

    logic [FILL_WIDTH-1:0] fill;
    result_t               result_reg, result_next;
    logic                  done_reg;

    function automatic logic [COORD_WIDTH-1:0] project(
        input logic signed [COORD_WIDTH-1:0] base,
        input logic signed [COORD_WIDTH-1:0] origin,
        input logic [QUO_WIDTH-1:0]          q,
        input logic                          neg
    );
        logic signed [SUM_WIDTH-1:0] step;
        logic signed [SUM_WIDTH-1:0] total;
        step = signed'(SUM_WIDTH'(q));
        if (neg)
        begin
            step = -step;
        end
        total = SUM_WIDTH'(base) + step - SUM_WIDTH'(origin);
        // saturate when the bits above the sign differ from it
        if (total[SUM_WIDTH-1:COORD_WIDTH-1] == '0 || total[SUM_WIDTH-1:COORD_WIDTH-1] == '1)
        begin
            project = total[COORD_WIDTH-1:0];
        end
        else if (total[SUM_WIDTH-1])
        begin
            project = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            project = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    function automatic logic [7:0] chan(
        input logic [FILL_WIDTH-1:0] f,
        input logic [FILL_WIDTH-1:0] base
    );
        logic [FILL_WIDTH-1:0] d;
        d = f - base;
        if (f <= base)
        begin
            chan = '0;
        end
        else if (d > FILL_WIDTH'(CHAN_MAX))
        begin
            chan = CHAN_MAX;
        end
        else
        begin
            chan = d[7:0];
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LIGHT_X:       cfg_reg.light_x       <= wr_data;
                REG_LIGHT_Y:       cfg_reg.light_y       <= wr_data;
                REG_LIGHT_Z:       cfg_reg.light_z       <= wr_data;
                REG_LIGHT_RADIUS:  cfg_reg.light_radius  <= wr_data[COORD_WIDTH-2:0];
                REG_OBJECT_X:      cfg_reg.object_x      <= wr_data;
                REG_OBJECT_Y:      cfg_reg.object_y      <= wr_data;
                REG_OBJECT_Z:      cfg_reg.object_z      <= wr_data;
                REG_CASTER_HEIGHT: cfg_reg.caster_height <= wr_data[COORD_WIDTH-2:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    svp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (start && !busy),
        .item      (item),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    svp_sqrt u_sqrt (
        .clk      (clk),
        .radicand (front_data.sum_sq),
        .root     (root)
    );

    // carry the deltas alongside the root
    always_ff @(posedge clk)
    begin
        side_reg[0].dx       <= front_data.dx;
        side_reg[0].dy       <= front_data.dy;
        side_reg[0].dz       <= front_data.dz;
        side_reg[0].weight_r <= front_data.weight_r;
        for (int s = 1; s < ROOT_WIDTH; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    assign side_cur = side_reg[ROOT_WIDTH-1];

    always_comb
    begin
        above  = !side_cur.dz[DX_WIDTH-1];
        dx_neg = side_cur.dx[DX_WIDTH-1];
        dy_neg = side_cur.dy[DX_WIDTH-1];
        mag_dx = MAG_WIDTH'(dx_neg ? -side_cur.dx : side_cur.dx);
        mag_dy = MAG_WIDTH'(dy_neg ? -side_cur.dy : side_cur.dy);
        mag_dz = DEN_WIDTH'(side_cur.dz[DX_WIDTH-1] ? -side_cur.dz : side_cur.dz);
        lz_mag = COORD_WIDTH'(cfg_reg.light_z[COORD_WIDTH-1] ? -cfg_reg.light_z
                                                             : cfg_reg.light_z);
        lz_pos = !cfg_reg.light_z[COORD_WIDTH-1] && (cfg_reg.light_z != '0);
        dist_zero = above && (root == '0);
        scale = above ? COORD_WIDTH'(cfg_reg.light_radius) : lz_mag;

        num_x_next = dist_zero ? '0 : mag_dx * scale;
        num_y_next = dist_zero ? '0 : mag_dy * scale;
        num_f_next = side_cur.weight_r * cfg_reg.light_radius;
        if (!above)
        begin
            den_next = mag_dz;
        end
        else if (dist_zero)
        begin
            den_next = DEN_WIDTH'(1);
        end
        else
        begin
            den_next = root;
        end

        // ground cut divides by a negative dz with a negated light height
        sel_post_next.neg_x       = above ? dx_neg : (dx_neg ^ !lz_pos);
        sel_post_next.neg_y       = above ? dy_neg : (dy_neg ^ !lz_pos);
        sel_post_next.hits_ground = !above;
        sel_post_next.dist_zero   = dist_zero;
    end

    always_ff @(posedge clk)
    begin
        num_x_reg    <= num_x_next;
        num_y_reg    <= num_y_next;
        num_f_reg    <= num_f_next;
        den_reg      <= den_next;
        sel_post_reg <= sel_post_next;
        post_reg[0]  <= sel_post_reg;
        for (int s = 1; s < DIV_LAT; s++)
        begin
            post_reg[s] <= post_reg[s-1];
        end
        result_reg <= result_next;
    end

    svp_div u_div_x (
        .clk (clk),
        .num (num_x_reg),
        .den (den_reg),
        .quo (quo_x)
    );

    svp_div u_div_y (
        .clk (clk),
        .num (num_y_reg),
        .den (den_reg),
        .quo (quo_y)
    );

    svp_div u_div_f (
        .clk (clk),
        .num (num_f_reg),
        .den (den_reg),
        .quo (quo_f)
    );

    assign post_cur = post_reg[DIV_LAT-1];

    always_comb
    begin
        if (post_cur.hits_ground)
        begin
            fill = '0;
        end
        else if (post_cur.dist_zero || quo_f > QUO_WIDTH'(FILL_MAX))
        begin
            fill = FILL_MAX;
        end
        else
        begin
            fill = quo_f[FILL_WIDTH-1:0];
        end

        result_next.shadow_x = project(cfg_reg.light_x, cfg_reg.object_x, quo_x,
                                       post_cur.neg_x);
        result_next.shadow_y = project(cfg_reg.light_y, cfg_reg.object_y, quo_y,
                                       post_cur.neg_y);
        result_next.fill_r = chan(fill, '0);
        result_next.fill_g = chan(fill, FILL_WIDTH'(CHAN_STEP));
        result_next.fill_b = chan(fill, FILL_WIDTH'(2 * CHAN_STEP));
        result_next.fill_a = chan(fill, FILL_WIDTH'(3 * CHAN_STEP));
        result_next.hits_ground = post_cur.hits_ground;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_v_reg <= '0;
            sel_v_reg  <= 1'b0;
            post_v_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            side_v_reg <= {side_v_reg[ROOT_WIDTH-2:0], front_valid};
            sel_v_reg  <= side_v_reg[ROOT_WIDTH-1];
            post_v_reg <= {post_v_reg[DIV_LAT-2:0], sel_v_reg};
            done_reg   <= post_v_reg[DIV_LAT-1];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/svp_front.sv =====
// Front stages: deltas to the light, height raise and squared horizontal distance.
`timescale 1ns / 1ps

module svp_front
    import svp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  item_t  item,
    output logic   out_valid,
    output front_t out_data
);

    localparam int XW          = HPROD_WIDTH - 2;
    localparam int TERMS       = (XW + 7) / 8;
    localparam int REM_WIDTH   = 12;
    localparam int RAISE_WIDTH = COORD_WIDTH - 1;
    localparam int CORR_WIDTH  = $clog2(TERMS + 1);
    localparam int STAGES      = 6;

    logic [STAGES-1:0] valid_reg, valid_next;

    logic signed [DX_WIDTH-1:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic [WSUM_WIDTH-1:0]      wsum1_reg, wsum1_next;
    logic [7:0]                 wr1_reg, wr1_next;

    logic [HPROD_WIDTH-1:0]     hprod2_reg, hprod2_next;
    logic [2*MAG_WIDTH-1:0]     sqx2_reg, sqx2_next, sqy2_reg, sqy2_next;
    logic signed [DX_WIDTH-1:0] dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [7:0]                 wr2_reg, wr2_next;

    logic [REM_WIDTH-1:0]       xlow3_reg, xlow3_next;
    logic [RAISE_WIDTH-1:0]     qe3_reg, qe3_next;
    front_t                     f3_reg, f3_next;

    logic [REM_WIDTH-1:0]       rem4_reg, rem4_next;
    logic [RAISE_WIDTH-1:0]     qe4_reg, qe4_next;
    front_t                     f4_reg, f4_next;

    logic [RAISE_WIDTH-1:0]     raise5_reg, raise5_next;
    front_t                     f5_reg, f5_next;

    front_t                     f6_reg, f6_next;

    logic [MAG_WIDTH-1:0]       mag_x, mag_y;
    logic [XW-1:0]              x_val;
    logic [RAISE_WIDTH-1:0]     qe_low_ext;
    logic [REM_WIDTH-1:0]       qe_low;
    logic [CORR_WIDTH-1:0]      corr;

    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], in_valid};

        dx1_next = DX_WIDTH'(cfg.object_x) + DX_WIDTH'(item.offset_x)
                   - DX_WIDTH'(cfg.light_x);
        dy1_next = DX_WIDTH'(cfg.object_y) + DX_WIDTH'(item.offset_y)
                   - DX_WIDTH'(cfg.light_y);
        wsum1_next = WSUM_WIDTH'(item.weight_r) + WSUM_WIDTH'(item.weight_g)
                     + WSUM_WIDTH'(item.weight_b) + WSUM_WIDTH'(item.weight_a);
        wr1_next = item.weight_r;

        mag_x = MAG_WIDTH'(dx1_reg[DX_WIDTH-1] ? -dx1_reg : dx1_reg);
        mag_y = MAG_WIDTH'(dy1_reg[DX_WIDTH-1] ? -dy1_reg : dy1_reg);
        hprod2_next = cfg.caster_height * wsum1_reg;
        sqx2_next = mag_x * mag_x;
        sqy2_next = mag_y * mag_y;
        dx2_next = dx1_reg;
        dy2_next = dy1_reg;
        wr2_next = wr1_reg;

        // x/255 as the sum of x/256^k; the estimate runs low by a few units
        x_val = hprod2_reg[HPROD_WIDTH-1:2];
        qe_low_ext = '0;
        for (int k = 1; k <= TERMS; k++)
        begin
            qe_low_ext = qe_low_ext + RAISE_WIDTH'(x_val >> (8 * k));
        end
        qe3_next = qe_low_ext;
        xlow3_next = x_val[REM_WIDTH-1:0];
        f3_next.dx = dx2_reg;
        f3_next.dy = dy2_reg;
        f3_next.dz = '0;
        f3_next.sum_sq = SQ_WIDTH'(sqx2_reg) + SQ_WIDTH'(sqy2_reg);
        f3_next.weight_r = wr2_reg;

        // remainder is small, so low bits are enough
        qe_low = qe3_reg[REM_WIDTH-1:0];
        rem4_next = xlow3_reg - (qe_low << 8) + qe_low;
        qe4_next = qe3_reg;
        f4_next = f3_reg;

        corr = '0;
        for (int j = 1; j <= TERMS; j++)
        begin
            if (rem4_reg >= REM_WIDTH'(CHAN_STEP * j))
            begin
                corr = corr + CORR_WIDTH'(1);
            end
        end
        raise5_next = qe4_reg + RAISE_WIDTH'(corr);
        f5_next = f4_reg;

        f6_next = f5_reg;
        f6_next.dz = DX_WIDTH'(cfg.object_z) + DX_WIDTH'(raise5_reg)
                     - DX_WIDTH'(cfg.light_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg    <= dx1_next;
        dy1_reg    <= dy1_next;
        wsum1_reg  <= wsum1_next;
        wr1_reg    <= wr1_next;
        hprod2_reg <= hprod2_next;
        sqx2_reg   <= sqx2_next;
        sqy2_reg   <= sqy2_next;
        dx2_reg    <= dx2_next;
        dy2_reg    <= dy2_next;
        wr2_reg    <= wr2_next;
        xlow3_reg  <= xlow3_next;
        qe3_reg    <= qe3_next;
        f3_reg     <= f3_next;
        rem4_reg   <= rem4_next;
        qe4_reg    <= qe4_next;
        f4_reg     <= f4_next;
        raise5_reg <= raise5_next;
        f5_reg     <= f5_next;
        f6_reg     <= f6_next;
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = f6_reg;

endmodule

// ===== hw/rtl/svp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module svp_sqrt
    import svp_pkg::*;
(
    input  logic                  clk,
    input  logic [SQ_WIDTH-1:0]   radicand,
    output logic [ROOT_WIDTH-1:0] root
);

    localparam int PAD   = 2 * ROOT_WIDTH;
    localparam int REM_W = ROOT_WIDTH + 3;

    logic [PAD-1:0]        rad_reg  [ROOT_WIDTH];
    logic [PAD-1:0]        rad_next [ROOT_WIDTH];
    logic [REM_W-1:0]      rem_reg  [ROOT_WIDTH];
    logic [REM_W-1:0]      rem_next [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] root_reg [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] root_next[ROOT_WIDTH];

    logic [PAD-1:0]        rad_cur;
    logic [REM_W-1:0]      rem_cur, acc, trial;
    logic [ROOT_WIDTH-1:0] root_cur;

    always_comb
    begin
        for (int s = 0; s < ROOT_WIDTH; s++)
        begin
            if (s == 0)
            begin
                rad_cur  = PAD'(radicand);
                rem_cur  = '0;
                root_cur = '0;
            end
            else
            begin
                rad_cur  = rad_reg[s-1];
                rem_cur  = rem_reg[s-1];
                root_cur = root_reg[s-1];
            end
            acc   = {rem_cur[REM_W-3:0], rad_cur[PAD-1 -: 2]};
            trial = REM_W'({root_cur, 2'b01});
            if (acc >= trial)
            begin
                rem_next[s]  = acc - trial;
                root_next[s] = {root_cur[ROOT_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = acc;
                root_next[s] = {root_cur[ROOT_WIDTH-2:0], 1'b0};
            end
            rad_next[s] = rad_cur << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ROOT_WIDTH; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
        end
    end

    assign root = root_reg[ROOT_WIDTH-1];

endmodule

// ===== hw/rtl/svp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
`timescale 1ns / 1ps

module svp_div
    import svp_pkg::*;
(
    input  logic                 clk,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic [QUO_WIDTH-1:0] quo
);

    localparam int HI_WIDTH = NUM_WIDTH - QUO_WIDTH;

    logic [DEN_WIDTH-1:0] rem_reg  [QUO_WIDTH+1];
    logic [DEN_WIDTH-1:0] rem_next [QUO_WIDTH+1];
    logic [DEN_WIDTH-1:0] den_reg  [QUO_WIDTH+1];
    logic [DEN_WIDTH-1:0] den_next [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] low_reg  [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] low_next [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] q_reg    [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] q_next   [QUO_WIDTH+1];
    logic                 ovf_reg  [QUO_WIDTH+1];
    logic                 ovf_next [QUO_WIDTH+1];

    logic [HI_WIDTH-1:0]  num_hi;
    logic [DEN_WIDTH:0]   cat;

    always_comb
    begin
        // top bits must stay below the divisor or the quotient cannot fit
        num_hi      = num[NUM_WIDTH-1:QUO_WIDTH];
        rem_next[0] = DEN_WIDTH'(num_hi);
        ovf_next[0] = DEN_WIDTH'(num_hi) >= den;
        den_next[0] = den;
        low_next[0] = num[QUO_WIDTH-1:0];
        q_next[0]   = '0;
        for (int s = 1; s <= QUO_WIDTH; s++)
        begin
            cat = {rem_reg[s-1], low_reg[s-1][QUO_WIDTH-1]};
            if (cat >= {1'b0, den_reg[s-1]})
            begin
                rem_next[s] = DEN_WIDTH'(cat - {1'b0, den_reg[s-1]});
                q_next[s]   = {q_reg[s-1][QUO_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = cat[DEN_WIDTH-1:0];
                q_next[s]   = {q_reg[s-1][QUO_WIDTH-2:0], 1'b0};
            end
            low_next[s] = low_reg[s-1] << 1;
            den_next[s] = den_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= QUO_WIDTH; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_next[s];
            low_reg[s] <= low_next[s];
            q_reg[s]   <= q_next[s];
            ovf_reg[s] <= ovf_next[s];
        end
    end

    assign quo = ovf_reg[QUO_WIDTH] ? '1 : q_reg[QUO_WIDTH];

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the shadow vertex projector.
`timescale 1ns / 1ps

module testbench;
    import svp_pkg::*;

    localparam int  LATENCY     = 60;
    localparam int  CYCLE_LIMIT = 200000;
    localparam longint COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -(64'sd1 <<< (COORD_WIDTH - 1));

    typedef struct {
        item_t   vtx;
        bit      typed;
        result_t want;
    } vertex_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    item_t                      item;
    logic                       done;
    result_t                    result;
    logic                       wr_en;
    logic [CFG_INDEX_WIDTH-1:0] wr_index;
    logic [COORD_WIDTH-1:0]     wr_data;

    cfg_t    scene;
    result_t shadow_queue[$];
    bit      took;
    bit      typed_now;
    result_t typed_want;
    bit      idle_on;
    int      errors;
    int      cycles;
    int      sent;
    int      ground_seen;
    int      push_seen;

    shadow_vertex_projector DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // trunc(a*b/c), clamped to +-2^62
    function automatic longint scaled_quotient(longint a, longint b, longint c);
        bit                   neg;
        longint unsigned      q;
        neg = ((a < 0) != (b < 0)) != (c < 0);
        q = (magnitude(a) * magnitude(b)) / magnitude(c);
        if (q > (64'd1 << 62))
            q = 64'd1 << 62;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned sq);
        longint unsigned root;
        logic [127:0]    trial;
        root = 0;
        for (int b = 40; b >= 0; b--)
        begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= 128'(sq))
                root = root | (64'd1 << b);
        end
        return root;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
        if (v > COORD_HI)
            v = COORD_HI;
        else if (v < COORD_LO)
            v = COORD_LO;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [7:0] chan_of(longint unsigned fill, int step);
        longint unsigned base;
        base = 255 * step;
        if (fill <= base)
            return 8'd0;
        return (fill - base > 255) ? 8'd255 : 8'(fill - base);
    endfunction

    function automatic result_t project_vertex(item_t v);
        result_t         r;
        longint          lx, ly, lz, obx, oby, obz, dx, dy, dz, px, py;
        longint unsigned rad, hgt, raise, span, fill;
        lx  = scene.light_x;
        ly  = scene.light_y;
        lz  = scene.light_z;
        obx = scene.object_x;
        oby = scene.object_y;
        obz = scene.object_z;
        rad = scene.light_radius;
        hgt = scene.caster_height;
        raise = hgt * (v.weight_r + v.weight_g + v.weight_b + v.weight_a) / 1020;
        dx = obx + longint'(v.offset_x) - lx;
        dy = oby + longint'(v.offset_y) - ly;
        dz = obz + longint'(raise) - lz;
        fill = 0;
        r.hits_ground = 1'b0;
        if (dz >= 0)
        begin
            span = floor_root(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy));
            if (span == 0)
            begin
                px = lx;
                py = ly;
                fill = 1020;
            end
            else
            begin
                px = lx + scaled_quotient(dx, longint'(rad), longint'(span));
                py = ly + scaled_quotient(dy, longint'(rad), longint'(span));
                fill = v.weight_r * rad / span;
            end
        end
        else
        begin
            px = lx + scaled_quotient(dx, -lz, dz);
            py = ly + scaled_quotient(dy, -lz, dz);
            r.hits_ground = 1'b1;
        end
        if (fill > 1020)
            fill = 1020;
        r.shadow_x = clamp_coord(px - obx);
        r.shadow_y = clamp_coord(py - oby);
        r.fill_r = chan_of(fill, 0);
        r.fill_g = chan_of(fill, 1);
        r.fill_b = chan_of(fill, 2);
        r.fill_a = chan_of(fill, 3);
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
    endtask

    // Record transfers in, check results out.
    always @(posedge clk)
    begin
        result_t w;
        took <= start && !busy;
        if (rst_n && start && !busy)
            shadow_queue.push_back(typed_now ? typed_want : project_vertex(item));
        if (rst_n && done)
        begin
            if (shadow_queue.size() == 0)
            begin
                errors++;
                $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                w = shadow_queue.pop_front();
                if (result.shadow_x !== w.shadow_x)
                    report("shadow_x", result.shadow_x, w.shadow_x);
                if (result.shadow_y !== w.shadow_y)
                    report("shadow_y", result.shadow_y, w.shadow_y);
                if (result.fill_r !== w.fill_r)
                    report("fill_r", result.fill_r, w.fill_r);
                if (result.fill_g !== w.fill_g)
                    report("fill_g", result.fill_g, w.fill_g);
                if (result.fill_b !== w.fill_b)
                    report("fill_b", result.fill_b, w.fill_b);
                if (result.fill_a !== w.fill_a)
                    report("fill_a", result.fill_a, w.fill_a);
                if (result.hits_ground !== w.hits_ground)
                    report("hits_ground", result.hits_ground, w.hits_ground);
                if (w.hits_ground)
                    ground_seen++;
                else
                    push_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] data);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = data;
        case (idx)
            REG_LIGHT_X:       scene.light_x       = data;
            REG_LIGHT_Y:       scene.light_y       = data;
            REG_LIGHT_Z:       scene.light_z       = data;
            REG_LIGHT_RADIUS:  scene.light_radius  = data[COORD_WIDTH-2:0];
            REG_OBJECT_X:      scene.object_x      = data;
            REG_OBJECT_Y:      scene.object_y      = data;
            REG_OBJECT_Z:      scene.object_z      = data;
            REG_CASTER_HEIGHT: scene.caster_height = data[COORD_WIDTH-2:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic load_scene(cfg_t s);
        write_reg(REG_LIGHT_X, s.light_x);
        write_reg(REG_LIGHT_Y, s.light_y);
        write_reg(REG_LIGHT_Z, s.light_z);
        write_reg(REG_LIGHT_RADIUS, COORD_WIDTH'(s.light_radius));
        write_reg(REG_OBJECT_X, s.object_x);
        write_reg(REG_OBJECT_Y, s.object_y);
        write_reg(REG_OBJECT_Z, s.object_z);
        write_reg(REG_CASTER_HEIGHT, COORD_WIDTH'(s.caster_height));
    endtask

    // Hold the sender until the pipeline is empty.
    task automatic drain();
        start = 1'b0;
        while (shadow_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic send_vertex(item_t v, bit typed, result_t want);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        start      = 1'b1;
        item       = v;
        typed_now  = typed;
        typed_want = want;
        sent++;
        @(negedge clk);
        while (!took)
            @(negedge clk);
    endtask

    function automatic item_t random_vertex();
        item_t v;
        int    mode;
        mode = $urandom_range(0, 9);
        v.offset_x = COORD_WIDTH'($urandom);
        v.offset_y = COORD_WIDTH'($urandom);
        if (mode < 4)
        begin
            v.offset_x = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 8191))) - 4096);
            v.offset_y = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 8191))) - 4096);
        end
        else if (mode == 4)
        begin
            // land exactly under the light
            v.offset_x = scene.light_x - scene.object_x;
            v.offset_y = scene.light_y - scene.object_y;
        end
        v.weight_r = 8'($urandom);
        v.weight_g = 8'($urandom);
        v.weight_b = 8'($urandom);
        v.weight_a = 8'($urandom);
        if (mode == 5)
            v.weight_r = 8'd255;
        return v;
    endfunction

    function automatic cfg_t random_scene();
        cfg_t s;
        s = $bits(cfg_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
        begin
            // ordinary scene: light up high, caster near the ground
            s.light_x  = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 65535))) - 32768);
            s.light_y  = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 65535))) - 32768);
            s.light_z  = COORD_WIDTH'($urandom_range(0, 40000));
            s.object_x = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 65535))) - 32768);
            s.object_y = COORD_WIDTH'($signed(COORD_WIDTH'($urandom_range(0, 65535))) - 32768);
            s.object_z = COORD_WIDTH'($urandom_range(0, 20000));
            s.light_radius  = (COORD_WIDTH - 1)'($urandom_range(0, 200000));
            s.caster_height = (COORD_WIDTH - 1)'($urandom_range(0, 60000));
        end
        return s;
    endfunction

    initial
    begin
        vertex_row_t rows[$];
        vertex_row_t row;
        cfg_t        s;
        result_t     zero_res;
        result_t     full_res;

        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = REG_LIGHT_X;
        wr_data = '0;
        scene = '0;
        typed_now = 1'b0;
        typed_want = '0;
        idle_on = 1'b1;
        errors = 0;
        cycles = 0;
        sent = 0;
        ground_seen = 0;
        push_seen = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        zero_res = '0;
        full_res = '0;
        full_res.fill_r = 8'd255;
        full_res.fill_g = 8'd255;
        full_res.fill_b = 8'd255;
        full_res.fill_a = 8'd255;

        // Registers at reset: every vertex collapses onto the origin.
        rows = '{
            '{'{24'sd0, 24'sd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, full_res},
            '{'{24'sd0, 24'sd0, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, full_res},
            '{'{24'sh7FFFFF, 24'sh800000, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b1, zero_res},
            '{'{24'sh800000, 24'sh7FFFFF, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b1, zero_res},
            '{'{24'sd1, 24'sd0, 8'd255, 8'd255, 8'd0, 8'd0}, 1'b1, zero_res}
        };
        foreach (rows[i])
            send_vertex(rows[i].vtx, rows[i].typed, rows[i].want);
        drain();

        // Extreme scenes, then a plain ground-cut scene.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: s = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF,
                         24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF};
                1: s = '{24'sh800000, 24'sh800000, 24'sh800000, 23'h7FFFFF,
                         24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 23'h0};
                2: s = '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 23'h0,
                         24'sh7FFFFF, 24'sh800000, 24'sh800000, 23'h7FFFFF};
                default: s = '{24'sd0, 24'sd0, 24'sd25600, 23'd12800,
                               24'sd256, 24'sd512, 24'sd0, 23'd2560};
            endcase
            load_scene(s);
            rows = '{
                '{'{24'sd0, 24'sd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, zero_res},
                '{'{24'sh7FFFFF, 24'sh7FFFFF, 8'd255, 8'd255, 8'd255, 8'd255},
                  1'b0, zero_res},
                '{'{24'sh800000, 24'sh800000, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, zero_res},
                '{'{24'sh7FFFFF, 24'sh800000, 8'd128, 8'd1, 8'd2, 8'd3}, 1'b0, zero_res}
            };
            row.vtx = '{scene.light_x - scene.object_x, scene.light_y - scene.object_y,
                        8'd200, 8'd0, 8'd0, 8'd0};
            row.typed = 1'b0;
            rows.push_back(row);
            foreach (rows[i])
                send_vertex(rows[i].vtx, rows[i].typed, rows[i].want);
            drain();
        end

        // Random scenes; the last one runs with no sender gaps.
        for (int ph = 0; ph < 10; ph++)
        begin
            load_scene(random_scene());
            idle_on = (ph != 9);
            for (int n = 0; n < 50; n++)
                send_vertex(random_vertex(), 1'b0, zero_res);
            drain();
        end

        $display("sent %0d vertices over 15 scenes, extremes included", sent);
        $display("checked %0d ground cuts and %0d radius pushes", ground_seen, push_seen);
        if (errors == 0 && shadow_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
